FILE: src/fir_pkg.sv
// Shared types, sizes and codes for the direct-form FIR filter.
// No dependencies; every other file in src uses it by scoped names.
`default_nettype none

package fir_pkg;

    localparam int MAX_TAPS    = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = SAMPLE_BITS - 1;
    localparam int ADDR_W      = $clog2(MAX_TAPS);
    localparam int LEN_W       = 7;
    localparam int INDEX_W     = 6;
    localparam int PROD_W      = 2 * SAMPLE_BITS;
    localparam int ACC_W       = 40;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [ADDR_W-1:0]             addr_t;
    typedef logic [LEN_W-1:0]              len_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [ACC_W-1:0]       acc_t;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_LOAD   = 1'b1;

    // Largest Q1.15 value, the nearest thing to unity gain.
    localparam sample_t COEF_UNITY = sample_t'((1 << FRAC_BITS) - 1);

    // Control that travels down the multiply-accumulate pipeline with each tap.
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } mac_ctl_t;

endpackage

`default_nettype wire

FILE: src/fir_delay_ram.sv
// Sample history memory, used as a circular buffer, with registered read.
// Entries never written read as zero. Depends on fir_pkg.
`default_nettype none

module fir_delay_ram (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             we,
    input  wire fir_pkg::addr_t   waddr,
    input  wire fir_pkg::sample_t wdata,
    input  wire fir_pkg::addr_t   raddr,
    output fir_pkg::sample_t      rdata
);

    fir_pkg::sample_t              mem [fir_pkg::MAX_TAPS];
    logic [fir_pkg::MAX_TAPS-1:0]  valid_reg;
    fir_pkg::sample_t              rd_reg;
    logic                          rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rd_vld_reg <= valid_reg[raddr];
        end
    end

    assign rdata = rd_vld_reg ? rd_reg : '0;

endmodule

`default_nettype wire

FILE: src/fir_coef_ram.sv
// Coefficient memory with registered read. An entry never loaded reads as
// its reset value: unity at tap 0, zero elsewhere. Depends on fir_pkg.
`default_nettype none

module fir_coef_ram (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             we,
    input  wire fir_pkg::addr_t   waddr,
    input  wire fir_pkg::sample_t wdata,
    input  wire fir_pkg::addr_t   raddr,
    output fir_pkg::sample_t      rdata
);

    fir_pkg::sample_t              mem [fir_pkg::MAX_TAPS];
    logic [fir_pkg::MAX_TAPS-1:0]  valid_reg;
    fir_pkg::sample_t              rd_reg;
    logic                          rd_vld_reg;
    logic                          rd_zero_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg      <= mem[raddr];
        rd_zero_reg <= (raddr == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rd_vld_reg <= valid_reg[raddr];
        end
    end

    always_comb
    begin
        if (rd_vld_reg)
        begin
            rdata = rd_reg;
        end
        else if (rd_zero_reg)
        begin
            rdata = fir_pkg::COEF_UNITY;
        end
        else
        begin
            rdata = '0;
        end
    end

endmodule

`default_nettype wire

FILE: src/fir_mac.sv
// Shared multiply-accumulate unit with round-half-up and saturation to Q1.15.
// One tap per cycle: multiply stage, then accumulate stage. Depends on fir_pkg.
`default_nettype none

module fir_mac (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire fir_pkg::mac_ctl_t ctl,
    input  wire fir_pkg::sample_t  samp,
    input  wire fir_pkg::sample_t  coef,
    output logic                   done,
    output fir_pkg::sample_t       y,
    output logic                   clip
);

    localparam fir_pkg::acc_t HALF = fir_pkg::acc_t'(1 << (fir_pkg::FRAC_BITS - 1));
    localparam fir_pkg::acc_t QMAX = fir_pkg::acc_t'((1 << fir_pkg::FRAC_BITS) - 1);
    localparam fir_pkg::acc_t QMIN = fir_pkg::acc_t'(-(1 << fir_pkg::FRAC_BITS));

    fir_pkg::prod_t    prod_reg;
    fir_pkg::mac_ctl_t ctl_a_reg;
    fir_pkg::acc_t     acc_reg;
    fir_pkg::acc_t     prod_ext;
    fir_pkg::acc_t     rounded;
    fir_pkg::acc_t     q;
    logic              done_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= fir_pkg::prod_t'(samp * coef);
        if (ctl_a_reg.vld)
        begin
            acc_reg <= ctl_a_reg.first ? prod_ext : fir_pkg::acc_t'(acc_reg + prod_ext);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            ctl_a_reg <= ctl;
            done_reg  <= ctl_a_reg.vld && ctl_a_reg.last;
        end
    end

    assign prod_ext = fir_pkg::acc_t'(prod_reg);

    // The accumulator holds its value until the next request starts, so the
    // rounded result stays valid for as long as the sequencer needs it.
    assign rounded = fir_pkg::acc_t'(acc_reg + HALF);
    assign q       = rounded >>> fir_pkg::FRAC_BITS;

    always_comb
    begin
        if (q > QMAX)
        begin
            y    = fir_pkg::sample_t'(QMAX);
            clip = 1'b1;
        end
        else if (q < QMIN)
        begin
            y    = fir_pkg::sample_t'(QMIN);
            clip = 1'b1;
        end
        else
        begin
            y    = fir_pkg::sample_t'(q);
            clip = 1'b0;
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

FILE: src/fir_filter_real.sv
// Direct-form real FIR filter: top level with the tap sequencer and output register.
// A sample request is registered at the output after one multiplier pass per tap, the length
// clamped to 1..64; a load writes one coefficient and leaves the block idle.
// A new request is taken the cycle after the result is registered, even while it waits.
// Reset clears control state at once; history reads as zero and taps as their defaults.
// Depends on fir_pkg, fir_delay_ram, fir_coef_ram and fir_mac.
`default_nettype none

module fir_filter_real (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            mode,
    input  wire fir_pkg::sample_t                sample_in,
    input  wire logic [fir_pkg::INDEX_W-1:0]     tap_index,
    input  wire fir_pkg::sample_t                tap_value,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output fir_pkg::sample_t                     sample_out,
    output logic                                 clipped,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire fir_pkg::len_t                   cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RUN  = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    fir_pkg::len_t     taps_reg;
    fir_pkg::addr_t    wp_reg, wp_next;
    fir_pkg::addr_t    base_reg, base_next;
    fir_pkg::addr_t    k_reg, k_next;
    fir_pkg::addr_t    last_reg, last_next;
    fir_pkg::mac_ctl_t ctl_issue;
    fir_pkg::mac_ctl_t ctl_d_reg;
    logic              out_valid_reg;
    fir_pkg::sample_t  sample_out_reg;
    logic              clipped_reg;

    logic              in_accept;
    logic              out_load;
    logic              delay_we;
    logic              coef_we;
    fir_pkg::addr_t    delay_raddr;
    fir_pkg::addr_t    last_eff;
    fir_pkg::sample_t  delay_rdata;
    fir_pkg::sample_t  coef_rdata;
    logic              mac_done;
    fir_pkg::sample_t  mac_y;
    logic              mac_clip;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Filter length clamped to 1..MAX_TAPS, held as the index of the last tap.
    always_comb
    begin
        if (taps_reg == '0)
        begin
            last_eff = '0;
        end
        else if (taps_reg > fir_pkg::len_t'(fir_pkg::MAX_TAPS))
        begin
            last_eff = fir_pkg::addr_t'(fir_pkg::MAX_TAPS - 1);
        end
        else
        begin
            last_eff = fir_pkg::addr_t'(taps_reg - fir_pkg::len_t'(1));
        end
    end

    assign delay_we = in_accept && (mode == fir_pkg::MODE_SAMPLE);
    assign coef_we  = in_accept && (mode == fir_pkg::MODE_LOAD)
                      && (int'(tap_index) < fir_pkg::MAX_TAPS);

    // The newest sample sits at base; x[n-k] is k entries behind it.
    assign delay_raddr = fir_pkg::addr_t'(base_reg - k_reg);

    always_comb
    begin
        ctl_issue.vld   = (state_reg == ST_RUN);
        ctl_issue.first = (k_reg == '0);
        ctl_issue.last  = (k_reg == last_reg);
    end

    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        wp_next    = wp_reg;
        base_next  = base_reg;
        k_next     = k_reg;
        last_next  = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (delay_we)
                begin
                    base_next  = wp_reg;
                    wp_next    = fir_pkg::addr_t'(wp_reg + 1'b1);
                    k_next     = '0;
                    last_next  = last_eff;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                k_next = fir_pkg::addr_t'(k_reg + 1'b1);
                if (k_reg == last_reg)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (mac_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            taps_reg      <= fir_pkg::len_t'(1);
            wp_reg        <= '0;
            base_reg      <= '0;
            k_reg         <= '0;
            last_reg      <= '0;
            ctl_d_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            base_reg  <= base_next;
            k_reg     <= k_next;
            last_reg  <= last_next;
            ctl_d_reg <= ctl_issue;
            if (cfg_valid && cfg_ready)
            begin
                taps_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            sample_out_reg <= mac_y;
            clipped_reg    <= mac_clip;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign clipped    = clipped_reg;

    fir_delay_ram u_delay (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (delay_we),
        .waddr (wp_reg),
        .wdata (sample_in),
        .raddr (delay_raddr),
        .rdata (delay_rdata)
    );

    fir_coef_ram u_coef (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (coef_we),
        .waddr (fir_pkg::addr_t'(tap_index)),
        .wdata (tap_value),
        .raddr (k_reg),
        .rdata (coef_rdata)
    );

    fir_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl_d_reg),
        .samp  (delay_rdata),
        .coef  (coef_rdata),
        .done  (mac_done),
        .y     (mac_y),
        .clip  (mac_clip)
    );

    // The accumulator finishes only while the sequencer waits for it.
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> (state_reg == ST_WAIT))
        else $error("accumulation finished outside the wait state");

    // The tap counter never runs past the last tap of the filter.
    a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (k_reg <= last_reg))
        else $error("tap counter beyond filter length");

    // A load request leaves the block idle and produces no result.
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (mode == fir_pkg::MODE_LOAD)) |=> (state_reg == ST_IDLE))
        else $error("load request started a filter pass");

    // A sample request writes the history pointer forward by one.
    a_wp_step: assert property (@(posedge clk) disable iff (!rst_n)
        delay_we |=> (wp_reg == fir_pkg::addr_t'($past(wp_reg) + 1'b1)))
        else $error("history pointer did not advance");

endmodule

`default_nettype wire
